// ===== sv/kvt_pkg.sv =====
// Shared types and constants for the key/value table.
// Used by kvt_ctrl, kvt_dp and key_value_table; no dependencies.
package kvt_pkg;

  localparam int unsigned DEF_ENTRIES    = 128;
  localparam int unsigned DEF_KEY_BITS   = 64;
  localparam int unsigned DEF_VALUE_BITS = 64;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned STAT_W = 3;

  localparam logic [CMD_W-1:0] CMD_PUT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_GET = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DEL = 2'd2;

  typedef enum logic [STAT_W-1:0] {
    STAT_STORED  = 3'd0,
    STAT_FOUND   = 3'd1,
    STAT_EMPTY   = 3'd2,
    STAT_MISSING = 3'd3,
    STAT_DELETED = 3'd4,
    STAT_FULL    = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic    load;
    logic    scan_en;
    logic    wr_hit;
    logic    append;
    logic    shift_start;
    logic    shift_en;
    logic    dec_count;
    logic    res_load;
    status_e res_status;
    logic    res_use_rd;
    logic    out_load;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             cnt_zero;
    logic             cnt_full;
    logic             hit;
    logic             miss;
    logic             shift_done;
    logic             out_free;
  } dp_status_t;

endpackage

// ===== sv/key_value_table.sv =====
// Top level of the key/value table: put, get and delete on unique keys.
// Depends on kvt_pkg, kvt_ctrl, kvt_dp (which holds two kvt_ram stores).
//
//   channel  direction  handshake               fields
//   in       sink       in_valid_i/in_ready_o   command_i, key_i, value_i
//   out      source     out_valid_o/out_ready_i status_o, read_value_o
//
// One word is in flight at a time. A scan reads one stored key per cycle, at most
// the n stored entries (n up to the entry count). A delete that removes the last
// entry moves nothing; else each later entry is moved down one place, through
// the single read port of each store that the scan also uses. Reset empties the
// table at once (entry count to zero); the stores are not cleared.
// A stalled output holds its word while the next input word is taken and searched.
module key_value_table #(
  parameter int unsigned ENTRIES    = kvt_pkg::DEF_ENTRIES,
  parameter int unsigned KEY_BITS   = kvt_pkg::DEF_KEY_BITS,
  parameter int unsigned VALUE_BITS = kvt_pkg::DEF_VALUE_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [kvt_pkg::CMD_W-1:0]  command_i,
  input  logic [KEY_BITS-1:0]        key_i,
  input  logic [VALUE_BITS-1:0]      value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [kvt_pkg::STAT_W-1:0] status_o,
  output logic [VALUE_BITS-1:0]      read_value_o
);
  import kvt_pkg::*;

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_stat;

  kvt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (dp_stat),
    .cmd_o      (ctrl_cmd)
  );

  kvt_dp #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (ctrl_cmd),
    .stat_o       (dp_stat),
    .command_i    (command_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .read_value_o (read_value_o)
  );

endmodule

// ===== sv/kvt_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module kvt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/kvt_ctrl.sv =====
// Sequencer for the key/value table: decode, scan, compaction, response.
// Depends on kvt_pkg; drives kvt_dp through ctrl_cmd_t.
module kvt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  kvt_pkg::dp_status_t stat_i,
  output kvt_pkg::ctrl_cmd_t  cmd_o
);
  import kvt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.res_status = STAT_MISSING;
    in_ready_o       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_START;
        end
      end
      S_START: begin
        if (stat_i.cnt_zero) begin
          // nothing to search: answer straight away
          cmd_o.res_load = 1'b1;
          state_d        = S_RESP;
          priority if (stat_i.cmd == CMD_PUT) begin
            cmd_o.append     = 1'b1;
            cmd_o.res_status = STAT_STORED;
          end else if (stat_i.cmd == CMD_GET) begin
            cmd_o.res_status = STAT_EMPTY;
          end else begin
            cmd_o.res_status = STAT_MISSING;
          end
        end else if (stat_i.cmd == CMD_PUT || stat_i.cmd == CMD_GET ||
                     stat_i.cmd == CMD_DEL) begin
          cmd_o.scan_en = 1'b1;
          state_d       = S_SCAN;
        end else begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = STAT_MISSING;
          state_d          = S_RESP;
        end
      end
      S_SCAN: begin
        priority if (stat_i.hit) begin
          priority if (stat_i.cmd == CMD_PUT) begin
            cmd_o.wr_hit     = 1'b1;
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = STAT_STORED;
            state_d          = S_RESP;
          end else if (stat_i.cmd == CMD_GET) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = STAT_FOUND;
            cmd_o.res_use_rd = 1'b1;
            state_d          = S_RESP;
          end else begin
            cmd_o.shift_start = 1'b1;
            state_d           = S_SHIFT;
          end
        end else if (stat_i.miss) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_RESP;
          priority if (stat_i.cmd == CMD_PUT && stat_i.cnt_full) begin
            cmd_o.res_status = STAT_FULL;
          end else if (stat_i.cmd == CMD_PUT) begin
            cmd_o.append     = 1'b1;
            cmd_o.res_status = STAT_STORED;
          end else begin
            cmd_o.res_status = STAT_MISSING;
          end
        end else begin
          cmd_o.scan_en = 1'b1;
        end
      end
      S_SHIFT: begin
        if (stat_i.shift_done) begin
          cmd_o.dec_count  = 1'b1;
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = STAT_DELETED;
          state_d          = S_RESP;
        end else begin
          cmd_o.shift_en = 1'b1;
        end
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/kvt_dp.sv =====
// Datapath of the key/value table: key and value stores, scan and move
// pointers, entry count, result and output registers. Depends on kvt_pkg, kvt_ram.
module kvt_dp #(
  parameter int unsigned ENTRIES    = kvt_pkg::DEF_ENTRIES,
  parameter int unsigned KEY_BITS   = kvt_pkg::DEF_KEY_BITS,
  parameter int unsigned VALUE_BITS = kvt_pkg::DEF_VALUE_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  kvt_pkg::ctrl_cmd_t         cmd_i,
  output kvt_pkg::dp_status_t        stat_o,
  input  logic [kvt_pkg::CMD_W-1:0]  command_i,
  input  logic [KEY_BITS-1:0]        key_i,
  input  logic [VALUE_BITS-1:0]      value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [kvt_pkg::STAT_W-1:0] status_o,
  output logic [VALUE_BITS-1:0]      read_value_o
);
  import kvt_pkg::*;

  localparam int unsigned AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(ENTRIES);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  logic [CMD_W-1:0]      cmd_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [CNT_W-1:0]      count_q;
  logic [CNT_W-1:0]      scan_q;   // next address to read
  logic [CNT_W-1:0]      chk_q;    // address whose data is on the read port
  logic                  chk_vld_q;
  logic [CNT_W-1:0]      mv_q;     // compaction write address
  logic                  mv_vld_q;
  status_e               res_stat_q;
  logic [VALUE_BITS-1:0] res_val_q;
  status_e               stat_q;
  logic [VALUE_BITS-1:0] rdval_q;
  logic                  out_vld_q;

  logic                  issue;
  logic                  move;
  logic [AW-1:0]         raddr;
  logic                  key_we;
  logic                  val_we;
  logic [AW-1:0]         key_waddr;
  logic [AW-1:0]         val_waddr;
  logic [KEY_BITS-1:0]   key_wdata;
  logic [VALUE_BITS-1:0] val_wdata;
  logic [KEY_BITS-1:0]   key_rdata;
  logic [VALUE_BITS-1:0] val_rdata;
  logic                  match;

  // one read a cycle, shared between scan and compaction
  assign issue = (cmd_i.scan_en || cmd_i.shift_en) && (scan_q != count_q);
  assign move  = cmd_i.shift_en && mv_vld_q;
  assign raddr = scan_q[AW-1:0];
  assign match = chk_vld_q && (key_rdata == key_q);

  assign key_we    = cmd_i.append || move;
  assign key_waddr = cmd_i.append ? count_q[AW-1:0] : mv_q[AW-1:0];
  assign key_wdata = cmd_i.append ? key_q : key_rdata;

  assign val_we    = cmd_i.append || cmd_i.wr_hit || move;
  always_comb begin
    priority if (cmd_i.append) begin
      val_waddr = count_q[AW-1:0];
      val_wdata = val_q;
    end else if (cmd_i.wr_hit) begin
      val_waddr = chk_q[AW-1:0];
      val_wdata = val_q;
    end else begin
      val_waddr = mv_q[AW-1:0];
      val_wdata = val_rdata;
    end
  end

  kvt_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .raddr_i (raddr),
    .rdata_o (key_rdata)
  );

  kvt_ram #(.WIDTH(VALUE_BITS), .DEPTH(ENTRIES)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .raddr_i (raddr),
    .rdata_o (val_rdata)
  );

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= command_i;
      key_q <= key_i;
      val_q <= value_i;
    end
    if (issue) begin
      chk_q <= scan_q;
    end
    if (cmd_i.res_load) begin
      res_stat_q <= cmd_i.res_status;
      res_val_q  <= cmd_i.res_use_rd ? val_rdata : '0;
    end
    if (cmd_i.out_load) begin
      stat_q  <= res_stat_q;
      rdval_q <= res_val_q;
    end
    if (cmd_i.shift_start) begin
      mv_q <= chk_q;
    end else if (move) begin
      mv_q <= mv_q + CNT_ONE;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      scan_q    <= '0;
      chk_vld_q <= 1'b0;
      mv_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.append) begin
        count_q <= count_q + CNT_ONE;
      end else if (cmd_i.dec_count) begin
        count_q <= count_q - CNT_ONE;
      end

      if (cmd_i.load) begin
        scan_q <= '0;
      end else if (cmd_i.shift_start) begin
        scan_q <= chk_q + CNT_ONE;
      end else if (issue) begin
        scan_q <= scan_q + CNT_ONE;
      end

      chk_vld_q <= cmd_i.scan_en && issue;
      mv_vld_q  <= cmd_i.shift_en && issue;

      if (cmd_i.out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_comb begin
    stat_o.cmd        = cmd_q;
    stat_o.cnt_zero   = (count_q == '0);
    stat_o.cnt_full   = (count_q == CNT_MAX);
    stat_o.hit        = match;
    stat_o.miss       = chk_vld_q && !match && ((chk_q + CNT_ONE) == count_q);
    stat_o.shift_done = (scan_q == count_q) && !mv_vld_q;
    stat_o.out_free   = !out_vld_q || out_ready_i;
  end

  assign out_valid_o  = out_vld_q;
  assign status_o     = stat_q;
  assign read_value_o = rdval_q;

endmodule
